[design/dip_pkg.sv]
// Shared types and constants for the dotted IPv4 text parser.
// Used by dip_core and dotted_ipv4_text_parser_top; no dependencies.
`timescale 1ns / 1ps

package dip_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_START  = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  // Result of one character step, core to top
  typedef struct packed {
    logic      give;
    out_item_t item;
  } step_res_t;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [31:0] BYTE_MAX = 32'h0000_00ff;

  // Widest value allowed for the last part, by stored part count
  function automatic logic [31:0] last_part_max(input logic [1:0] parts);
    logic [31:0] m;
    case (parts)
      2'd0:    m = 32'hffff_ffff;
      2'd1:    m = 32'h00ff_ffff;
      2'd2:    m = 32'h0000_ffff;
      default: m = 32'h0000_00ff;
    endcase
    return m;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0d]});
  endfunction

endpackage

[design/dip_core.sv]
// Parser state and single-character step logic for the dotted IPv4 parser.
// Depends on dip_pkg.
`timescale 1ns / 1ps

module dip_core
  import dip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  logic      commit_i,
  output step_res_t res_o
);

  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d;
  logic [31:0] value_q, value_d;
  logic        ovf_q, ovf_d;
  logic        seen_q, seen_d;
  logic [1:0]  parts_q, parts_d;
  logic [23:0] upper_q, upper_d;

  always_comb begin
    logic [7:0]  c;
    phase_e      ph;
    radix_e      rad;
    logic        seen;
    logic [1:0]  parts;
    logic [23:0] upper;
    logic        collect;
    logic        is_digit;
    logic [3:0]  dig;
    logic [35:0] wide;
    logic [35:0] nv;

    c        = item_i.character;
    ph       = phase_q;
    rad      = radix_q;
    seen     = seen_q;
    parts    = parts_q;
    upper    = upper_q;
    collect  = 1'b0;
    is_digit = 1'b0;
    dig      = 4'd0;
    wide     = {4'b0, value_q};
    nv       = '0;

    phase_d = phase_q;
    radix_d = radix_q;
    value_d = value_q;
    ovf_d   = ovf_q;
    seen_d  = seen_q;
    parts_d = parts_q;
    upper_d = upper_q;
    res_o   = '0;

    if (item_i.first) begin
      parts = 2'd0;
      upper = '0;
      ph    = PH_START;
    end
    phase_d = ph;
    parts_d = parts;
    upper_d = upper;

    case (ph)
      PH_DONE: ;
      PH_START: begin
        if (!is_dec(c)) begin
          res_o.give = 1'b1;
          phase_d    = PH_DONE;
        end else begin
          ovf_d   = 1'b0;
          radix_d = RX_DEC;
          if (c == 8'h30) begin
            value_d = '0;
            seen_d  = 1'b0;
            phase_d = PH_ZERO;
          end else begin
            value_d = {28'b0, c[3:0]};
            seen_d  = 1'b1;
            phase_d = PH_DIGITS;
          end
        end
      end
      PH_ZERO: begin
        phase_d = PH_DIGITS;
        if (c == 8'h78 || c == 8'h58) begin
          radix_d = RX_HEX;
          seen_d  = 1'b0;
        end else begin
          rad     = RX_OCT;
          seen    = 1'b1;
          radix_d = RX_OCT;
          seen_d  = 1'b1;
          collect = 1'b1;
        end
      end
      PH_DIGITS: collect = 1'b1;
      default: ;
    endcase

    if (collect) begin
      if (is_dec(c)) begin
        is_digit = 1'b1;
        dig      = c[3:0];
      end else if (rad == RX_HEX && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
        is_digit = 1'b1;
        dig      = 4'(c[2:0] + 3'd1) + 4'd8;
      end

      // value * radix as shifts and one add
      case (rad)
        RX_HEX:  nv = (wide << 4) + {32'b0, dig};
        RX_OCT:  nv = (wide << 3) + {32'b0, dig};
        default: nv = (wide << 3) + (wide << 1) + {32'b0, dig};
      endcase

      if (is_digit) begin
        if (rad == RX_OCT && dig[3]) begin
          res_o.give = 1'b1;
          phase_d    = PH_DONE;
        end else begin
          value_d = nv[31:0];
          ovf_d   = ovf_q | (nv[35:32] != 4'd0);
          seen_d  = 1'b1;
        end
      end else if (c == CH_DOT) begin
        if (parts == 2'd3 || ovf_q || value_q > BYTE_MAX) begin
          res_o.give = 1'b1;
          phase_d    = PH_DONE;
        end else begin
          case (parts)
            2'd0:    upper_d = upper | {value_q[7:0], 16'b0};
            2'd1:    upper_d = upper | {8'b0, value_q[7:0], 8'b0};
            default: upper_d = upper | {16'b0, value_q[7:0]};
          endcase
          parts_d = parts + 2'd1;
          phase_d = PH_START;
        end
      end else begin
        res_o.give = 1'b1;
        phase_d    = PH_DONE;
        if ((c == CH_NUL || is_blank(c)) && parts != 2'd0 && seen && !ovf_q &&
            value_q <= last_part_max(parts)) begin
          res_o.item.valid_res = 1'b1;
          res_o.item.address   = {upper, 8'b0} | value_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      radix_q <= RX_DEC;
      value_q <= '0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
      parts_q <= '0;
      upper_q <= '0;
    end else if (commit_i) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      value_q <= value_d;
      ovf_q   <= ovf_d;
      seen_q  <= seen_d;
      parts_q <= parts_d;
      upper_q <= upper_d;
    end
  end

endmodule

[design/dotted_ipv4_text_parser_top.sv]
// Top level of the dotted IPv4 text parser: input register, step core and
// result register. Depends on dip_pkg and dip_core.
//
// Usage: characters of an address string enter on the in_* channel, one per
// transfer, with first set on the opening character of each string. When a
// string ends (NUL or whitespace) or fails, one result leaves on the out_*
// channel: valid_res and the 32-bit address (zero when not valid). A first
// transfer mid-string drops the string in progress without a result.
// A character sits in the input register while the core takes its step; its
// result (if any) is then registered in the result register, which drives
// the out_* channel. Throughput: one character per cycle, by way of the
// shift-add step in dip_core, while the result register can take any result
// that the character produces.
// When the receiver stalls, the result register holds; characters that cause
// no result keep flowing until one that needs the output register arrives.
// Reset: both pipeline registers empty, parser idle until a first character.
`timescale 1ns / 1ps

module dotted_ipv4_text_parser_top
  import dip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  step_res_t res;
  logic      out_free;
  logic      advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!res.give || out_free);
  assign in_ready_o = !in_valid_q || advance;

  dip_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_q),
    .commit_i(advance),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.give;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.give) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.valid_res || out_q.address == 32'd0))
    else $error("invalid result with non-zero address");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("input stage lost a stalled character");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.give) |=> out_valid_q)
    else $error("result step did not load the output register");
`endif

endmodule
